@@ rtl/core/rrsf_pkg.sv @@
`timescale 1ns / 1ps
// shared field widths, constants and types of the rounded rectangle span fill
package rrsf_pkg;

    localparam int XY_W         = 16;
    localparam int DIM_W        = 15;
    localparam int RAD_IN_W     = 5;
    localparam int COLOR_W      = 32;
    localparam int SPAN_W       = 17;

    // arithmetic width for coordinates before truncation to span width
    localparam int CALC_W       = SPAN_W + 1;

    // margin added to twice the radius before the width clamp
    localparam int WIDTH_MARGIN = 4;
    // rows kept free of corners by the height clamp
    localparam int HEIGHT_MARGIN = 2;
    // radius from which corners are drawn row by row
    localparam int CORNER_MIN   = 3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

@@ rtl/core/rounded_rect_span_fill.sv @@
`timescale 1ns / 1ps
// rounded rectangle span rasterizer: radius clamp, span sequencer, output register
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  request  | in        | i_in_valid / o_in_stall   | rect origin, size, radius, color
//  span     | out       | o_out_valid / i_out_stall | span corners, color, last_span
//
//  a request steps through the width clamp, height clamp and plan states, then
//  yields one full span, or a body span if any and then the corner rows; each
//  corner row waits for the square root unit, which does one result bit a cycle
//  each span waits in the output register until taken; o_in_stall stays high
//  from acceptance until the final span is transferred
//  zero width or height requests are dropped in the acceptance cycle
//  reset is synchronous and clears the sequencer and the output valid
module rounded_rect_span_fill #(
    parameter int MAX_RADIUS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [rrsf_pkg::XY_W-1:0]    i_rect_left,
    input  logic signed [rrsf_pkg::XY_W-1:0]    i_rect_top,
    input  logic        [rrsf_pkg::DIM_W-1:0]   i_rect_width,
    input  logic        [rrsf_pkg::DIM_W-1:0]   i_rect_height,
    input  logic        [rrsf_pkg::RAD_IN_W-1:0] i_corner_radius,
    input  logic        [rrsf_pkg::COLOR_W-1:0] i_fill_color,
    input  logic                                i_round_top,
    input  logic                                i_round_bottom,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rrsf_pkg::SPAN_W-1:0]  o_span_left,
    output logic signed [rrsf_pkg::SPAN_W-1:0]  o_span_top,
    output logic signed [rrsf_pkg::SPAN_W-1:0]  o_span_right,
    output logic signed [rrsf_pkg::SPAN_W-1:0]  o_span_bottom,
    output logic        [rrsf_pkg::COLOR_W-1:0] o_span_color,
    output logic                                o_last_span
);
    import rrsf_pkg::*;

    localparam int RW = $clog2(MAX_RADIUS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP_W,
        S_CLAMP_H,
        S_PLAN,
        S_ROW,
        S_SQRT,
        S_OUT
    } t_state;

    typedef enum logic {
        PH_TOP,
        PH_BOT
    } t_phase;

    t_state                    r_state;
    t_phase                    r_phase;
    logic [RW-1:0]             r_row;
    logic [RW-1:0]             r_rad;
    logic [RW-1:0]             r_top_r;
    logic [RW-1:0]             r_bot_r;
    logic [RW-1:0]             r_cur_r;
    logic signed [XY_W-1:0]    r_x0;
    logic signed [XY_W-1:0]    r_y0;
    logic [DIM_W-1:0]          r_w;
    logic [DIM_W-1:0]          r_h;
    logic [COLOR_W-1:0]        r_color;
    logic                      r_out_valid;
    logic                      r_last;
    logic [SPAN_W-1:0]         r_span_left;
    logic [SPAN_W-1:0]         r_span_top;
    logic [SPAN_W-1:0]         r_span_right;
    logic [SPAN_W-1:0]         r_span_bottom;

    logic [RW-1:0]             n_rad_sat;
    logic [RW-1:0]             n_top_h;
    logic [RW-1:0]             n_bot_h;
    logic [DIM_W:0]            n_corner_sum;
    logic [DIM_W-2:0]          n_cap;
    logic [RW-1:0]             n_cap_r;
    logic                      n_single;
    logic                      n_has_body;
    logic [RW-1:0]             n_cur_r;
    logic [RW-1:0]             n_dy;
    logic [2*RW-1:0]           n_radicand;
    logic                      n_row_go;
    logic                      n_sqrt_start;
    logic [RW-1:0]             n_root;
    t_sqrt_stat                n_sqrt_stat;
    logic signed [RW:0]        n_ins;
    logic signed [CALC_W-1:0]  n_x0e;
    logic signed [CALC_W-1:0]  n_y0e;
    logic signed [CALC_W-1:0]  n_we;
    logic signed [CALC_W-1:0]  n_he;
    logic signed [CALC_W-1:0]  n_inse;
    logic signed [CALC_W-1:0]  n_row_y;
    logic                      n_row_last;

    function automatic logic [RW-1:0] clamp_w(input logic [RW-1:0] r,
                                              input logic [DIM_W-1:0] w);
        logic [DIM_W:0]   need;
        logic [DIM_W-3:0] quarter;
        need    = (DIM_W+1)'({r, 1'b0}) + (DIM_W+1)'(WIDTH_MARGIN);
        quarter = w[DIM_W-1:2];
        if (need > (DIM_W+1)'(w) && quarter < (DIM_W-2)'(r)) begin
            return RW'(quarter);
        end
        return r;
    endfunction

    assign n_rad_sat = (i_corner_radius > RAD_IN_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                                 : i_corner_radius[RW-1:0];

    // height clamp
    assign n_corner_sum = (DIM_W+1)'(r_top_r) + (DIM_W+1)'(r_bot_r)
                        + (DIM_W+1)'(HEIGHT_MARGIN);
    assign n_cap   = (r_h >= DIM_W'(HEIGHT_MARGIN)) ? (r_h[DIM_W-1:1] - (DIM_W-1)'(1))
                                                    : '0;
    assign n_cap_r = (n_cap > (DIM_W-1)'(r_rad)) ? r_rad : RW'(n_cap);
    always_comb begin
        n_top_h = r_top_r;
        n_bot_h = r_bot_r;
        if (n_corner_sum > (DIM_W+1)'(r_h)) begin
            if (r_top_r > n_cap_r) begin
                n_top_h = n_cap_r;
            end
            if (r_bot_r > n_cap_r) begin
                n_bot_h = n_cap_r;
            end
        end
    end

    assign n_single   = (int'(r_top_r) < CORNER_MIN) && (int'(r_bot_r) < CORNER_MIN);
    assign n_has_body = (DIM_W+1)'(r_h) > ((DIM_W+1)'(r_top_r) + (DIM_W+1)'(r_bot_r));

    // corner row radicand
    assign n_cur_r    = (r_phase == PH_TOP) ? r_top_r : r_bot_r;
    assign n_dy       = (r_phase == PH_TOP) ? (n_cur_r - RW'(1) - r_row) : r_row;
    assign n_radicand = (2*RW)'(n_cur_r) * (2*RW)'(n_cur_r)
                      - (2*RW)'(n_dy) * (2*RW)'(n_dy);
    assign n_row_go   = (n_cur_r != '0);
    assign n_sqrt_start = (r_state == S_ROW) && n_row_go;

    rrsf_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_sqrt_start),
        .i_radicand (n_radicand),
        .o_root     (n_root),
        .o_stat     (n_sqrt_stat)
    );

    // span coordinates
    assign n_ins   = $signed({1'b0, r_cur_r}) - $signed({1'b0, n_root}) - (RW+1)'(1);
    assign n_x0e   = CALC_W'(r_x0);
    assign n_y0e   = CALC_W'(r_y0);
    assign n_we    = $signed(CALC_W'(r_w));
    assign n_he    = $signed(CALC_W'(r_h));
    assign n_inse  = CALC_W'(n_ins);
    assign n_row_y = (r_phase == PH_TOP)
                   ? (n_y0e + $signed(CALC_W'(r_row)))
                   : (n_y0e + n_he - $signed(CALC_W'(r_bot_r)) + $signed(CALC_W'(r_row)));
    assign n_row_last = ((r_phase == PH_BOT) && (r_row == r_bot_r - RW'(1)))
                     || ((r_phase == PH_TOP) && (r_row == r_top_r - RW'(1))
                         && (r_bot_r == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= PH_TOP;
            r_row       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x0    <= i_rect_left;
                        r_y0    <= i_rect_top;
                        r_w     <= i_rect_width;
                        r_h     <= i_rect_height;
                        r_color <= i_fill_color;
                        r_rad   <= n_rad_sat;
                        r_top_r <= i_round_top ? n_rad_sat : '0;
                        r_bot_r <= i_round_bottom ? n_rad_sat : '0;
                        if (i_rect_width != '0 && i_rect_height != '0) begin
                            r_state <= S_CLAMP_W;
                        end
                    end
                end
                S_CLAMP_W: begin
                    r_top_r <= clamp_w(r_top_r, r_w);
                    r_bot_r <= clamp_w(r_bot_r, r_w);
                    r_state <= S_CLAMP_H;
                end
                S_CLAMP_H: begin
                    r_top_r <= n_top_h;
                    r_bot_r <= n_bot_h;
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_phase <= PH_TOP;
                    r_row   <= '0;
                    if (n_single) begin
                        r_span_left   <= SPAN_W'(n_x0e);
                        r_span_top    <= SPAN_W'(n_y0e);
                        r_span_right  <= SPAN_W'(n_x0e + n_we);
                        r_span_bottom <= SPAN_W'(n_y0e + n_he);
                        r_last        <= 1'b1;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_OUT;
                    end else if (n_has_body) begin
                        r_span_left   <= SPAN_W'(n_x0e);
                        r_span_top    <= SPAN_W'(n_y0e + $signed(CALC_W'(r_top_r)));
                        r_span_right  <= SPAN_W'(n_x0e + n_we);
                        r_span_bottom <= SPAN_W'(n_y0e + n_he - $signed(CALC_W'(r_bot_r)));
                        r_last        <= 1'b0;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (n_row_go) begin
                        r_cur_r <= n_cur_r;
                        r_state <= S_SQRT;
                    end else if (r_phase == PH_TOP) begin
                        r_phase <= PH_BOT;
                        r_row   <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (n_sqrt_stat.done) begin
                        r_span_left   <= SPAN_W'(n_x0e + n_inse);
                        r_span_top    <= SPAN_W'(n_row_y);
                        r_span_right  <= SPAN_W'(n_x0e + n_we - n_inse);
                        r_span_bottom <= SPAN_W'(n_row_y + CALC_W'(1));
                        r_last        <= n_row_last;
                        r_out_valid   <= 1'b1;
                        if (r_phase == PH_TOP && r_row == r_top_r - RW'(1)) begin
                            r_phase <= PH_BOT;
                            r_row   <= '0;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_last ? S_IDLE : S_ROW;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_span_left   = r_span_left;
    assign o_span_top    = r_span_top;
    assign o_span_right  = r_span_right;
    assign o_span_bottom = r_span_bottom;
    assign o_span_color  = r_color;
    assign o_last_span   = r_last;

endmodule

@@ rtl/core/rrsf_isqrt.sv @@
`timescale 1ns / 1ps
// iterative integer square root, two radicand bits per cycle
module rrsf_isqrt #(
    parameter int RW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*RW-1:0]       i_radicand,
    output logic [RW-1:0]         o_root,
    output rrsf_pkg::t_sqrt_stat  o_stat
);
    import rrsf_pkg::*;

    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [REM_W-1:0]  r_rem;
    logic [RW-1:0]     r_root;
    logic [2*RW-1:0]   r_rad_sh;

    logic [REM_W-1:0]  n_rem_sh;
    logic [REM_W-1:0]  n_trial;
    logic              n_ge;

    assign n_rem_sh = {r_rem[REM_W-3:0], r_rad_sh[2*RW-1 -: 2]};
    assign n_trial  = {1'b0, r_root, 2'b01};
    assign n_ge     = (n_rem_sh >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt    <= CNT_W'(RW);
                r_rem    <= '0;
                r_root   <= '0;
                r_rad_sh <= i_radicand;
            end else if (r_cnt != '0) begin
                r_rem    <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
                r_root   <= RW'({r_root, n_ge});
                r_rad_sh <= r_rad_sh << 2;
                r_cnt    <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

@@ rtl/core/rrsf_check.sv @@
`timescale 1ns / 1ps
// port level checks of the span fill, bound to the top level
module rrsf_check (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic signed [rrsf_pkg::XY_W-1:0]     i_rect_left,
    input logic signed [rrsf_pkg::XY_W-1:0]     i_rect_top,
    input logic        [rrsf_pkg::DIM_W-1:0]    i_rect_width,
    input logic        [rrsf_pkg::DIM_W-1:0]    i_rect_height,
    input logic        [rrsf_pkg::RAD_IN_W-1:0] i_corner_radius,
    input logic        [rrsf_pkg::COLOR_W-1:0]  i_fill_color,
    input logic                                 i_round_top,
    input logic                                 i_round_bottom,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [rrsf_pkg::SPAN_W-1:0]   o_span_left,
    input logic signed [rrsf_pkg::SPAN_W-1:0]   o_span_top,
    input logic signed [rrsf_pkg::SPAN_W-1:0]   o_span_right,
    input logic signed [rrsf_pkg::SPAN_W-1:0]   o_span_bottom,
    input logic        [rrsf_pkg::COLOR_W-1:0]  o_span_color,
    input logic                                 o_last_span
);
    import rrsf_pkg::*;

    // no new request while a span is pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while span pending");

    // spans are never empty
    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_right > o_span_left) && (o_span_bottom > o_span_top))
        else $error("empty span");

    // ready for a new request right after the final span transfer
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_span |=> !o_in_stall && !o_out_valid)
        else $error("not idle after final span");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_span_left) && $stable(o_span_top) && $stable(o_last_span))
        else $error("stalled span changed");

endmodule

bind rounded_rect_span_fill rrsf_check u_rrsf_check (.*);
